// ===== rtl/tgtr_pkg.sv =====
// Package: shared types and constants for the tile id resolver.
package tgtr_pkg;
	localparam int MAX_SHEETS = 8;
	localparam int SLOT_W = 3;
	localparam int DIM_W = 13;
	localparam int TILE_W = 11;
	localparam int PIX_W = 8;
	localparam int GID_W = 32;
	localparam int CNT_W = 4;
	localparam int DIV_W = 32;
	localparam int DCNT_W = 6;
	localparam logic ACT_WRITE = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE, ST_COLS, ST_ROWS, ST_WSTORE,
		ST_SCAN, ST_CHECK, ST_DIV, ST_MULX, ST_MULY, ST_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic start_cols;
		logic start_rows;
		logic store_slot;
		logic scan_clear;
		logic read_slot;
		logic scan_next;
		logic start_idx_div;
		logic mul_x;
		logic mul_y;
		logic emit_hit;
		logic emit_miss;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic scan_end;
		logic hit;
	} sts_t;
endpackage

// ===== rtl/tgtr_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module tgtr_divider import tgtr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [DIV_W-1:0] remainder
);
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DCNT_W-1:0] cnt_q;
	logic busy_q;
	logic [DIV_W:0] trial;

	assign trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule

// ===== rtl/tgtr_datapath.sv =====
// Datapath: slot table, divider, range check and origin multiply.
module tgtr_datapath import tgtr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [CNT_W-1:0]  tileset_count,
	input  logic [SLOT_W-1:0] slot,
	input  logic [GID_W-1:0]  gid,
	input  logic              has_texture,
	input  logic [GID_W-1:0]  base_gid,
	input  logic [DIM_W-1:0]  sheet_width,
	input  logic [DIM_W-1:0]  sheet_height,
	input  logic [TILE_W-1:0] tile_width,
	input  logic [TILE_W-1:0] tile_height,
	input  logic [PIX_W-1:0]  margin,
	input  logic [PIX_W-1:0]  spacing,
	output logic              found,
	output logic [SLOT_W-1:0] matched_slot,
	output logic [DIM_W-1:0]  origin_x,
	output logic [DIM_W-1:0]  origin_y,
	output logic [TILE_W-1:0] match_tile_width,
	output logic [TILE_W-1:0] match_tile_height
);
	logic [MAX_SHEETS-1:0] valid_q;
	logic [GID_W-1:0]  mem_first [MAX_SHEETS];
	logic [DIM_W-1:0]  mem_cols  [MAX_SHEETS];
	logic [DIM_W-1:0]  mem_rows  [MAX_SHEETS];
	logic [TILE_W-1:0] mem_tw    [MAX_SHEETS];
	logic [TILE_W-1:0] mem_th    [MAX_SHEETS];
	logic [PIX_W-1:0]  mem_mg    [MAX_SHEETS];
	logic [PIX_W-1:0]  mem_sp    [MAX_SHEETS];

	// latched item
	logic              in_tex_q;
	logic [SLOT_W-1:0] in_slot_q;
	logic [GID_W-1:0]  in_gid_q;
	logic [GID_W-1:0]  in_first_q;
	logic [DIM_W-1:0]  in_sw_q, in_sh_q;
	logic [TILE_W-1:0] in_tw_q, in_th_q;
	logic [PIX_W-1:0]  in_mg_q, in_sp_q;
	logic [DIM_W-1:0]  cols_q;

	// scanned slot
	logic [SLOT_W:0]   scan_q;
	logic              rd_valid_q;
	logic [GID_W-1:0]  rd_first_q;
	logic [DIM_W-1:0]  rd_cols_q, rd_rows_q;
	logic [TILE_W-1:0] rd_tw_q, rd_th_q;
	logic [PIX_W-1:0]  rd_mg_q, rd_sp_q;
	logic [2*DIM_W-1:0] total_q;
	logic [CNT_W-1:0]  limit;

	logic              div_start;
	logic [DIV_W-1:0]  div_a, div_b, div_q, div_r;
	logic              div_done;

	logic [DIM_W:0]    border, usable_w, usable_h;
	logic [TILE_W:0]   pitch_w, pitch_h;
	logic [GID_W:0]    last_gid;
	logic [GID_W-1:0]  idx;
	logic              in_range;

	assign border = {(DIM_W-PIX_W)'(0), in_mg_q, 1'b0};
	assign usable_w = ({1'b0, in_sw_q} > border) ? {1'b0, in_sw_q} - border : '0;
	assign usable_h = ({1'b0, in_sh_q} > border) ? {1'b0, in_sh_q} - border : '0;
	assign pitch_w = {1'b0, in_tw_q} + {(TILE_W-PIX_W+1)'(0), in_sp_q};
	assign pitch_h = {1'b0, in_th_q} + {(TILE_W-PIX_W+1)'(0), in_sp_q};

	always_comb begin
		div_a = '0;
		div_b = '0;
		if (cmd.start_cols) begin
			div_a = DIV_W'(usable_w);
			div_b = DIV_W'(pitch_w);
		end else if (cmd.start_rows) begin
			div_a = DIV_W'(usable_h);
			div_b = DIV_W'(pitch_h);
		end else begin
			div_a = idx;
			div_b = DIV_W'(rd_cols_q);
		end
	end
	assign div_start = cmd.start_cols | cmd.start_rows | cmd.start_idx_div;

	tgtr_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b),
		.done(div_done), .quotient(div_q), .remainder(div_r)
	);

	assign limit = (tileset_count > CNT_W'(MAX_SHEETS)) ? CNT_W'(MAX_SHEETS) : tileset_count;
	assign idx = in_gid_q - rd_first_q;
	assign last_gid = {1'b0, rd_first_q} + (GID_W+1)'(total_q) - 1'b1;
	assign in_range = rd_valid_q && (total_q != '0) && (in_gid_q >= rd_first_q)
		&& ({1'b0, in_gid_q} <= last_gid);

	assign sts.div_done = div_done;
	assign sts.scan_end = (scan_q >= limit);
	assign sts.hit = in_range;

	// zero pitch gives a zero count
	logic pitch_zero_q;
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_tex_q <= has_texture;
			in_slot_q <= slot;
			in_gid_q <= gid;
			in_first_q <= base_gid;
			in_sw_q <= sheet_width;
			in_sh_q <= sheet_height;
			in_tw_q <= tile_width;
			in_th_q <= tile_height;
			in_mg_q <= margin;
			in_sp_q <= spacing;
		end
		if (div_start) pitch_zero_q <= (div_b == '0);
		if (cmd.start_rows) cols_q <= pitch_zero_q ? '0 : div_q[DIM_W-1:0];
		if (cmd.store_slot) begin
			mem_first[in_slot_q] <= in_first_q;
			mem_cols[in_slot_q] <= cols_q;
			mem_rows[in_slot_q] <= pitch_zero_q ? '0 : div_q[DIM_W-1:0];
			mem_tw[in_slot_q] <= in_tw_q;
			mem_th[in_slot_q] <= in_th_q;
			mem_mg[in_slot_q] <= in_mg_q;
			mem_sp[in_slot_q] <= in_sp_q;
		end
		if (cmd.read_slot) begin
			rd_first_q <= mem_first[scan_q[SLOT_W-1:0]];
			rd_cols_q <= mem_cols[scan_q[SLOT_W-1:0]];
			rd_rows_q <= mem_rows[scan_q[SLOT_W-1:0]];
			rd_tw_q <= mem_tw[scan_q[SLOT_W-1:0]];
			rd_th_q <= mem_th[scan_q[SLOT_W-1:0]];
			rd_mg_q <= mem_mg[scan_q[SLOT_W-1:0]];
			rd_sp_q <= mem_sp[scan_q[SLOT_W-1:0]];
		end
		if (cmd.scan_next) total_q <= rd_cols_q * rd_rows_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			scan_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.store_slot) valid_q[in_slot_q] <= in_tex_q;
			if (cmd.scan_clear) scan_q <= '0;
			else if (cmd.mul_x) scan_q <= scan_q + 1'b1;
			if (cmd.read_slot) rd_valid_q <= valid_q[scan_q[SLOT_W-1:0]];
		end
	end

	// origin computation; the result registers hold until the next resolve item
	logic [TILE_W:0] pw_m, ph_m;
	logic [DIM_W-1:0] col_q, row_q;
	assign pw_m = {1'b0, rd_tw_q} + {(TILE_W-PIX_W+1)'(0), rd_sp_q};
	assign ph_m = {1'b0, rd_th_q} + {(TILE_W-PIX_W+1)'(0), rd_sp_q};
	logic [DIM_W-1:0] mx_q;
	always_ff @(posedge clk) begin
		if (cmd.start_idx_div) begin
			col_q <= '0;
			row_q <= '0;
		end
		if (cmd.mul_x) begin
			col_q <= div_r[DIM_W-1:0];
			row_q <= div_q[DIM_W-1:0];
		end
		if (cmd.mul_y) mx_q <= DIM_W'(col_q * pw_m) + DIM_W'(rd_mg_q);
		if (cmd.emit_hit) begin
			matched_slot <= scan_q[SLOT_W-1:0] - 1'b1;
			origin_x <= mx_q;
			origin_y <= DIM_W'(row_q * ph_m) + DIM_W'(rd_mg_q);
			match_tile_width <= rd_tw_q;
			match_tile_height <= rd_th_q;
		end else if (cmd.emit_miss) begin
			matched_slot <= '0;
			origin_x <= '0;
			origin_y <= '0;
			match_tile_width <= '0;
			match_tile_height <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) found <= 1'b0;
		else if (cmd.emit_hit) found <= 1'b1;
		else if (cmd.emit_miss) found <= 1'b0;
	end
endmodule

// ===== rtl/tgtr_ctrl.sv =====
// Controller: sequences writes and slot scans.
module tgtr_ctrl import tgtr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic action,
	output logic busy,
	output logic done,
	output cmd_t cmd,
	input  sts_t sts
);
	state_t state_q, state_d;
	logic hit_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = (action == ACT_WRITE) ? ST_COLS : ST_SCAN;
			ST_COLS:   state_d = ST_ROWS;
			ST_ROWS:   if (sts.div_done) state_d = ST_WSTORE;
			ST_WSTORE: if (sts.div_done) state_d = ST_IDLE;
			ST_SCAN:   state_d = sts.scan_end ? ST_DONE : ST_CHECK;
			ST_CHECK:  state_d = ST_DIV;
			ST_DIV:    state_d = sts.hit ? ST_MULX : ST_SCAN;
			ST_MULX:   if (sts.div_done) state_d = ST_MULY;
			ST_MULY:   state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load_in = start;
				cmd.scan_clear = start && (action != ACT_WRITE);
			end
			ST_COLS:   cmd.start_cols = 1'b1;
			ST_ROWS:   cmd.start_rows = sts.div_done;
			ST_WSTORE: cmd.store_slot = sts.div_done;
			ST_SCAN: begin
				cmd.read_slot = 1'b1;
			end
			ST_CHECK:  cmd.scan_next = 1'b1;
			ST_DIV: begin
				cmd.start_idx_div = sts.hit;
				cmd.mul_x = !sts.hit;
			end
			ST_MULX:   cmd.mul_x = sts.div_done;
			ST_MULY:   cmd.mul_y = 1'b1;
			ST_DONE: begin
				cmd.emit_hit = hit_seen_q;
				cmd.emit_miss = !hit_seen_q;
				done = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hit_seen_q <= 1'b0;
		else if (cmd.scan_clear) hit_seen_q <= 1'b0;
		else if (state_q == ST_MULY) hit_seen_q <= 1'b1;
	end
endmodule

// ===== rtl/tile_gid_tileset_resolver.sv =====
// Top level: tile id to tile sheet coordinate resolver.
//  channel  | handshake           | payload
//  config   | tileset_count_we    | tileset_count_wdata
//  item in  | start & !busy       | action slot gid has_texture base_gid ...
//  result   | result_valid pulse  | found matched_slot origin_x/y match_tile_*
// A write item keeps busy high through two serial 32-step divisions, for columns and rows.
// A resolve item keeps busy high while it scans the slots, and on a hit also through the
// index division; the result strobe comes in the same cycle as busy drops.
// Reset clears the valid bits and the count; slot contents are kept until written.
// The result strobe lasts one cycle; the receiver cannot stall it.
module tile_gid_tileset_resolver import tgtr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tileset_count_we,
	input  logic [CNT_W-1:0]  tileset_count_wdata,
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [SLOT_W-1:0] slot,
	input  logic [GID_W-1:0]  gid,
	input  logic              has_texture,
	input  logic [GID_W-1:0]  base_gid,
	input  logic [DIM_W-1:0]  sheet_width,
	input  logic [DIM_W-1:0]  sheet_height,
	input  logic [TILE_W-1:0] tile_width,
	input  logic [TILE_W-1:0] tile_height,
	input  logic [PIX_W-1:0]  margin,
	input  logic [PIX_W-1:0]  spacing,
	output logic              result_valid,
	output logic              found,
	output logic [SLOT_W-1:0] matched_slot,
	output logic [DIM_W-1:0]  origin_x,
	output logic [DIM_W-1:0]  origin_y,
	output logic [TILE_W-1:0] match_tile_width,
	output logic [TILE_W-1:0] match_tile_height
);
	logic [CNT_W-1:0] count_q;
	cmd_t cmd;
	sts_t sts;
	logic done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (tileset_count_we) count_q <= tileset_count_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= done;
	end

	tgtr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action),
		.busy(busy), .done(done), .cmd(cmd), .sts(sts)
	);

	tgtr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.tileset_count(count_q), .slot(slot), .gid(gid),
		.has_texture(has_texture), .base_gid(base_gid),
		.sheet_width(sheet_width), .sheet_height(sheet_height),
		.tile_width(tile_width), .tile_height(tile_height),
		.margin(margin), .spacing(spacing),
		.found(found), .matched_slot(matched_slot),
		.origin_x(origin_x), .origin_y(origin_y),
		.match_tile_width(match_tile_width), .match_tile_height(match_tile_height)
	);
endmodule
